>>> rtl/pmp_pkg.sv
// Package for the pose motion predictor: widths, command codes and shared types.
`default_nettype none
package pmp_pkg;

   localparam int POS_WIDTH      = 32;
   localparam int QUAT_WIDTH     = 16;
   localparam int QUAT_FRAC_BITS = 14;
   localparam int VEL_EXTRA_FRAC = 16;
   localparam int LV_WIDTH       = 48;
   localparam int CMD_WIDTH      = 2;

   // Division by 1000 as a multiply by ceil(2^38 / 1000) and a shift by 38.
   // The error term 56 * 2^32 stays below 2^38, so this is exact for any
   // unsigned 32-bit dividend.
   localparam int LIN_DIVISOR    = 1000;
   localparam int RECIP_1000     = 274877907;
   localparam int RECIP_SHIFT    = 38;

   localparam logic [CMD_WIDTH-1:0] CMD_PREDICT = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_UPDATE  = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_RESET   = 2'd2;

   localparam logic signed [QUAT_WIDTH-1:0] QUAT_ONE = 16'sd16384;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]         command;
      logic signed [POS_WIDTH-1:0]  pos_x;
      logic signed [POS_WIDTH-1:0]  pos_y;
      logic signed [POS_WIDTH-1:0]  pos_z;
      logic signed [QUAT_WIDTH-1:0] rot_w;
      logic signed [QUAT_WIDTH-1:0] rot_x;
      logic signed [QUAT_WIDTH-1:0] rot_y;
      logic signed [QUAT_WIDTH-1:0] rot_z;
   } req_type;

   typedef struct packed {
      logic signed [POS_WIDTH-1:0]  pred_x;
      logic signed [POS_WIDTH-1:0]  pred_y;
      logic signed [POS_WIDTH-1:0]  pred_z;
      logic signed [QUAT_WIDTH-1:0] pred_w;
      logic signed [QUAT_WIDTH-1:0] pred_qx;
      logic signed [QUAT_WIDTH-1:0] pred_qy;
      logic signed [QUAT_WIDTH-1:0] pred_qz;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/pmp_if.sv
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface pmp_req_if import pmp_pkg::*; ;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface pmp_rsp_if import pmp_pkg::*; ;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/pmp_divider.sv
// Restoring divider, one quotient bit per cycle, unsigned 64 by 40 bits.
`default_nettype none
module pmp_divider import pmp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] numer,
   input  wire logic [39:0] denom,
   output logic             done,
   output logic [63:0]      quot
);
   logic [63:0] q_ff, q_in;
   logic [40:0] r_ff, r_in;
   logic [39:0] d_ff, d_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [40:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {r_ff[39:0], q_ff[63]};
      done = 1'b0;
      if (start) begin
         q_in = numer;
         r_in = '0;
         d_in = denom;
         cnt_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in = {q_ff[62:0], 1'b0};
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in[0] = 1'b1;
         end else begin
            r_in = trial;
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done = 1'b1;
         end
      end
   end

   assign quot = q_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end
endmodule
`default_nettype wire

>>> rtl/pose_motion_predictor.sv
// Top level of the pose motion predictor.
`default_nettype none
// Constant-velocity pose predictor. Each request beat carries a command and a
// pose. Update folds the pose into smoothed linear and angular velocity,
// reset loads the pose and clears the velocities, predict returns one
// response beat with position plus velocity and the rotation advanced by the
// angular velocity. An update computes the linear velocity (division by 1000
// through a reciprocal product), the quaternion product, the dot product and
// squares, the square root (one bit a cycle) and the four normalization
// divisions on a shared 64-step bit-serial divider. A predict runs a second
// product and normalization and then waits on the response beat. All products
// go through one 33x33 multiplier; the block takes no new request until it is
// back in idle, for a predict after the response beat has left.
module pose_motion_predictor import pmp_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   pmp_req_if.sink    req,
   pmp_rsp_if.source  rsp
);
   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_LDIV  = 12'b000000000010,
      S_LREM  = 12'b000000000100,
      S_LFRAC = 12'b000000001000,
      S_QMUL  = 12'b000000010000,
      S_DOT   = 12'b000000100000,
      S_SQ    = 12'b000001000000,
      S_SQRT  = 12'b000010000000,
      S_NDIV  = 12'b000100000000,
      S_NWAIT = 12'b001000000000,
      S_FIN   = 12'b010000000000,
      S_OUT   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   req_type   rq_ff, rq_in;
   rsp_type   rs_ff, rs_in;
   logic      pass_ff, pass_in;        // 0: angular velocity, 1: prediction
   logic [1:0] idx_ff, idx_in;
   logic [3:0] mc_ff, mc_in;           // product term counter
   logic [5:0] bc_ff, bc_in;           // square root bit counter

   logic signed [POS_WIDTH-1:0]  ppos_ff [3], ppos_in [3];
   logic signed [QUAT_WIDTH-1:0] prot_ff [4], prot_in [4];
   logic signed [LV_WIDTH-1:0]   lv_ff [3], lv_in [3];
   logic signed [QUAT_WIDTH-1:0] av_ff [4], av_in [4];
   logic signed [LV_WIDTH-1:0]   nlv_ff [3], nlv_in [3];
   logic signed [QUAT_WIDTH-1:0] nav_ff [4], nav_in [4];
   logic signed [QUAT_WIDTH-1:0] pq_ff [4], pq_in [4];
   // d holds the rounded product, later the sum to normalize
   logic signed [19:0] d_ff [4], d_in [4];
   logic signed [39:0] acc_ff, acc_in;
   logic signed [47:0] dot_ff, dot_in;
   logic [47:0] ss_ff, ss_in;
   logic [63:0] rem_ff, rem_in, sv_ff, sv_in;
   logic [31:0] root_ff, root_in;
   // linear velocity: whole quotient by 1000, magnitude or fraction term, sign
   logic [23:0] lq_ff, lq_in;
   logic [31:0] lt_ff, lt_in;
   logic        lneg_ff, lneg_in;

   // divider
   logic        dv_start, dv_done;
   logic [63:0] dv_num, dv_q;
   logic [39:0] dv_den;
   pmp_divider u_div (.clock, .reset, .start(dv_start), .numer(dv_num),
      .denom(dv_den), .done(dv_done), .quot(dv_q));

   // shared multiplier
   logic signed [32:0] ma, mb;
   logic signed [65:0] mp;
   assign mp = ma * mb;

   function automatic logic signed [QUAT_WIDTH-1:0] qsrc(input req_type r, input logic [1:0] i);
      logic signed [QUAT_WIDTH-1:0] v;
      case (i)
         2'd0: v = r.rot_w;
         2'd1: v = r.rot_x;
         2'd2: v = r.rot_y;
         default: v = r.rot_z;
      endcase
      return v;
   endfunction

   function automatic logic signed [POS_WIDTH-1:0] psrc(input req_type r, input logic [1:0] i);
      logic signed [POS_WIDTH-1:0] v;
      case (i)
         2'd0: v = r.pos_x;
         2'd1: v = r.pos_y;
         default: v = r.pos_z;
      endcase
      return v;
   endfunction

   // Hamilton product term table: a index, b index, negate
   function automatic logic [4:0] qterm(input logic [1:0] comp, input logic [1:0] t);
      logic [1:0] ai, bi;
      logic neg;
      ai = t;
      neg = 1'b0;
      case ({comp, t})
         4'h0: bi = 2'd0;
         4'h1: begin bi = 2'd1; neg = 1'b1; end
         4'h2: begin bi = 2'd2; neg = 1'b1; end
         4'h3: begin bi = 2'd3; neg = 1'b1; end
         4'h4: bi = 2'd1;
         4'h5: bi = 2'd0;
         4'h6: bi = 2'd3;
         4'h7: begin bi = 2'd2; neg = 1'b1; end
         4'h8: bi = 2'd2;
         4'h9: begin bi = 2'd3; neg = 1'b1; end
         4'hA: bi = 2'd0;
         4'hB: bi = 2'd1;
         4'hC: bi = 2'd3;
         4'hD: bi = 2'd2;
         4'hE: begin bi = 2'd1; neg = 1'b1; end
         default: bi = 2'd0;
      endcase
      return {ai, bi, neg};
   endfunction

   logic [4:0]  term;
   logic signed [39:0] acc_next, nlin;
   logic [39:0] amag;
   logic signed [POS_WIDTH-1:0] pcur;
   logic signed [POS_WIDTH:0] dpos;
   logic [POS_WIDTH-1:0] dmag;
   logic [31:0] lrem;
   logic [LV_WIDTH-1:0] vmag;
   logic signed [LV_WIDTH:0] vs;
   logic signed [LV_WIDTH-1:0] vr;
   logic [LV_WIDTH-1:0] vrm;
   logic signed [POS_WIDTH+1:0] psum;
   logic [19:0] cm;
   logic [63:0] trial, qres;
   logic signed [QUAT_WIDTH-1:0] qo;
   logic signed [19:0] cval;

   always_comb begin
      state_in = state_ff; rq_in = rq_ff; rs_in = rs_ff; pass_in = pass_ff;
      idx_in = idx_ff; mc_in = mc_ff; bc_in = bc_ff;
      ppos_in = ppos_ff; prot_in = prot_ff; lv_in = lv_ff; av_in = av_ff;
      nlv_in = nlv_ff; nav_in = nav_ff; pq_in = pq_ff; d_in = d_ff;
      acc_in = acc_ff; dot_in = dot_ff; ss_in = ss_ff; rem_in = rem_ff;
      sv_in = sv_ff; root_in = root_ff;
      lq_in = lq_ff; lt_in = lt_ff; lneg_in = lneg_ff;
      dv_start = 1'b0; dv_num = '0; dv_den = '0;
      ma = '0; mb = '0;
      term = qterm(idx_ff, mc_ff[1:0]);
      acc_next = '0; amag = '0; pcur = '0; dpos = '0; dmag = '0; lrem = '0;
      vmag = '0; vs = '0; vr = '0; vrm = '0; psum = '0; cm = '0; trial = '0;
      qres = '0; qo = '0; cval = '0; nlin = '0;
      req.ready = (state_ff == S_IDLE);
      rsp.valid = (state_ff == S_OUT);
      rsp.data = rs_ff;

      unique case (state_ff)
         S_IDLE: if (req.valid) begin
            rq_in = req.data;
            unique case (req.data.command)
               CMD_RESET: begin
                  ppos_in[0] = req.data.pos_x; ppos_in[1] = req.data.pos_y;
                  ppos_in[2] = req.data.pos_z;
                  prot_in[0] = req.data.rot_w; prot_in[1] = req.data.rot_x;
                  prot_in[2] = req.data.rot_y; prot_in[3] = req.data.rot_z;
                  for (int i = 0; i < 3; i++) lv_in[i] = '0;
                  av_in[0] = QUAT_ONE;
                  for (int i = 1; i < 4; i++) av_in[i] = '0;
               end
               CMD_PREDICT, CMD_UPDATE: begin
                  idx_in = '0; state_in = S_LDIV;
               end
               default: ;
            endcase
         end
         S_LDIV: begin
            pcur = psrc(rq_ff, idx_ff);
            dpos = {pcur[POS_WIDTH-1], pcur}
                 - {ppos_ff[idx_ff][POS_WIDTH-1], ppos_ff[idx_ff]};
            dmag = dpos[POS_WIDTH] ? POS_WIDTH'(-dpos) : dpos[POS_WIDTH-1:0];
            // Whole quotient |d| / 1000 by the reciprocal product.
            ma = {1'b0, dmag};
            mb = 33'(RECIP_1000);
            lq_in = mp[RECIP_SHIFT +: 24];
            lt_in = dmag;
            lneg_in = dpos[POS_WIDTH];
            state_in = S_LREM;
         end
         S_LREM: begin
            // The remainder scaled by 2^16 plus 500 gives the rounded fraction.
            ma = 33'(lq_ff);
            mb = 33'(LIN_DIVISOR);
            lrem = lt_ff - mp[31:0];
            lt_in = {lrem[15:0], 16'd0} + 32'd500;
            state_in = S_LFRAC;
         end
         S_LFRAC: begin
            ma = 33'(lt_ff);
            mb = 33'(RECIP_1000);
            vmag = {8'd0, lq_ff, 16'd0} + 48'(mp[RECIP_SHIFT +: 24]);
            vs = lneg_ff ? -{1'b0, vmag} : {1'b0, vmag};
            vs = vs + {lv_ff[idx_ff][LV_WIDTH-1], lv_ff[idx_ff]};
            nlv_in[idx_ff] = vs[LV_WIDTH] ? LV_WIDTH'(-((-vs + 1) >>> 1))
                                           : LV_WIDTH'(vs >>> 1);
            if (idx_ff == 2'd2) begin
               idx_in = '0; mc_in = '0; acc_in = '0; pass_in = 1'b0;
               state_in = S_QMUL;
            end else begin
               idx_in = idx_ff + 2'd1; state_in = S_LDIV;
            end
         end
         S_QMUL: begin
            // product of rq rotation with conj(prev) or with new angular velocity
            ma = 33'(qsrc(rq_ff, term[4:3]));
            if (!pass_ff) begin
               mb = (term[2:1] == 2'd0) ? 33'(prot_ff[0]) : -33'(prot_ff[term[2:1]]);
            end else begin
               mb = 33'(nav_ff[term[2:1]]);
            end
            acc_next = term[0] ? acc_ff - mp[39:0] : acc_ff + mp[39:0];
            acc_in = acc_next;
            mc_in = mc_ff + 4'd1;
            if (mc_ff[1:0] == 2'd3) begin
               amag = acc_next[39] ? -acc_next : acc_next;
               amag = (amag + 40'd8192) >> QUAT_FRAC_BITS;
               d_in[idx_ff] = acc_next[39] ? -20'(amag) : 20'(amag);
               acc_in = '0; mc_in = '0;
               if (idx_ff == 2'd3) begin
                  idx_in = '0; dot_in = '0;
                  state_in = pass_ff ? S_SQ : S_DOT;
                  ss_in = '0;
               end else idx_in = idx_ff + 2'd1;
            end
         end
         S_DOT: begin
            ma = 33'(d_ff[idx_ff]);
            mb = 33'(av_ff[idx_ff]);
            dot_in = dot_ff + 48'(mp);
            if (idx_ff == 2'd3) begin
               for (int i = 0; i < 4; i++)
                  d_in[i] = dot_in[47] ? d_ff[i] - 20'(av_ff[i]) : d_ff[i] + 20'(av_ff[i]);
               idx_in = '0; ss_in = '0; state_in = S_SQ;
            end else idx_in = idx_ff + 2'd1;
         end
         S_SQ: begin
            ma = 33'(d_ff[idx_ff]);
            mb = 33'(d_ff[idx_ff]);
            ss_in = ss_ff + 48'(mp[39:0]);
            if (idx_ff == 2'd3) begin
               sv_in = {ss_in, 16'd0}; rem_in = '0; root_in = '0; bc_in = '0;
               state_in = S_SQRT;
            end else idx_in = idx_ff + 2'd1;
         end
         S_SQRT: begin
            // one result bit per cycle
            rem_in = {rem_ff[61:0], sv_ff[63:62]};
            sv_in = {sv_ff[61:0], 2'b00};
            trial = 64'({root_ff[29:0], 2'b01});
            if (rem_in >= trial) begin
               rem_in = rem_in - trial;
               root_in = {root_ff[30:0], 1'b1};
            end else root_in = {root_ff[30:0], 1'b0};
            bc_in = bc_ff + 6'd1;
            if (bc_ff == 6'd31) begin
               idx_in = '0; state_in = S_NDIV;
            end
         end
         S_NDIV: begin
            if (root_ff == '0) begin
               for (int i = 0; i < 4; i++) begin
                  if (pass_ff) pq_in[i] = (i == 0) ? QUAT_ONE : '0;
                  else nav_in[i] = (i == 0) ? QUAT_ONE : '0;
               end
               state_in = S_FIN;
            end else begin
               cval = d_ff[idx_ff];
               cm = cval[19] ? -cval : cval;
               dv_num = ({44'd0, cm} << (QUAT_FRAC_BITS + 8)) + 64'(root_ff >> 1);
               dv_den = 40'(root_ff);
               dv_start = 1'b1;
               state_in = S_NWAIT;
            end
         end
         S_NWAIT: if (dv_done) begin
            cval = d_ff[idx_ff];
            qres = dv_q;
            if (qres > 64'd32768) qo = cval[19] ? -16'sd32768 : 16'sd32767;
            else if (qres == 64'd32768) qo = cval[19] ? -16'sd32768 : 16'sd32767;
            else qo = cval[19] ? -16'(qres) : 16'(qres);
            if (pass_ff) pq_in[idx_ff] = qo; else nav_in[idx_ff] = qo;
            if (idx_ff == 2'd3) state_in = S_FIN;
            else begin idx_in = idx_ff + 2'd1; state_in = S_NDIV; end
         end
         S_FIN: begin
            if (!pass_ff) begin
               if (rq_ff.command == CMD_UPDATE) begin
                  lv_in = nlv_ff; av_in = nav_ff;
                  ppos_in[0] = rq_ff.pos_x; ppos_in[1] = rq_ff.pos_y;
                  ppos_in[2] = rq_ff.pos_z;
                  prot_in[0] = rq_ff.rot_w; prot_in[1] = rq_ff.rot_x;
                  prot_in[2] = rq_ff.rot_y; prot_in[3] = rq_ff.rot_z;
                  state_in = S_IDLE;
               end else begin
                  pass_in = 1'b1; idx_in = '0; mc_in = '0; acc_in = '0;
                  state_in = S_QMUL;
               end
            end else begin
               for (int i = 0; i < 3; i++) begin
                  vr = nlv_ff[i];
                  vrm = vr[LV_WIDTH-1] ? -vr : vr;
                  vrm = (vrm + 48'd32768) >> VEL_EXTRA_FRAC;
                  pcur = psrc(rq_ff, 2'(i));
                  psum = {{2{pcur[POS_WIDTH-1]}}, pcur}
                       + (vr[LV_WIDTH-1] ? -34'(vrm) : 34'(vrm));
                  nlin = 40'(psum);
                  if (psum > 34'sh7FFFFFFF) nlin = 40'sh7FFFFFFF;
                  else if (psum < -34'sh80000000) nlin = -40'sh80000000;
                  if (i == 0) rs_in.pred_x = nlin[31:0];
                  else if (i == 1) rs_in.pred_y = nlin[31:0];
                  else rs_in.pred_z = nlin[31:0];
               end
               rs_in.pred_w = pq_ff[0]; rs_in.pred_qx = pq_ff[1];
               rs_in.pred_qy = pq_ff[2]; rs_in.pred_qz = pq_ff[3];
               state_in = S_OUT;
            end
         end
         S_OUT: if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass_ff <= 1'b0; idx_ff <= '0; mc_ff <= '0; bc_ff <= '0;
         for (int i = 0; i < 3; i++) begin ppos_ff[i] <= '0; lv_ff[i] <= '0; end
         for (int i = 0; i < 4; i++) begin
            prot_ff[i] <= (i == 0) ? QUAT_ONE : '0;
            av_ff[i]   <= (i == 0) ? QUAT_ONE : '0;
         end
      end else begin
         state_ff <= state_in;
         pass_ff <= pass_in; idx_ff <= idx_in; mc_ff <= mc_in; bc_ff <= bc_in;
         ppos_ff <= ppos_in; lv_ff <= lv_in; prot_ff <= prot_in; av_ff <= av_in;
      end
      rq_ff <= rq_in; rs_ff <= rs_in; nlv_ff <= nlv_in; nav_ff <= nav_in;
      pq_ff <= pq_in; d_ff <= d_in; acc_ff <= acc_in; dot_ff <= dot_in;
      ss_ff <= ss_in; rem_ff <= rem_in; sv_ff <= sv_in; root_ff <= root_in;
      lq_ff <= lq_in; lt_ff <= lt_in; lneg_ff <= lneg_in;
   end
endmodule
`default_nettype wire
